>>> rtl/esof_pkg.sv
package esof_pkg;

   // fixed arithmetic constants
   localparam int POT_MAX    = 1023;
   localparam int FRAC_BITS  = 8;
   localparam int WRAP_MOD   = 65535;

   // widths of the datapath
   localparam int PROD_W   = 26;                // step_span * pot_value
   localparam int STEP_W   = 17;                // step_min + scaled span
   localparam int LIMIT_W  = 26;                // glide_rate * elapsed
   localparam int SHOWN_W  = 32 + FRAC_BITS;    // signed displayed offset
   localparam int WIDE_W   = 48;                // lead / diff arithmetic

   // fraction mask for rounding toward zero
   localparam logic [WIDE_W-1:0] FRAC_MASK = (WIDE_W'(1) << FRAC_BITS) - WIDE_W'(1);

   // reciprocal of POT_MAX for the constant divide
   localparam int RECIP_SH = 36;
   localparam int RECIP_W  = 27;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / POT_MAX);
   localparam int QPROD_W  = PROD_W + RECIP_W;

   // register bus
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // register indexes
   localparam logic [2:0] REG_STEP_MIN     = 3'd0;
   localparam logic [2:0] REG_STEP_SPAN    = 3'd1;
   localparam logic [2:0] REG_MAX_DELTA    = 3'd2;
   localparam logic [2:0] REG_MAX_FRAME_MS = 3'd3;
   localparam logic [2:0] REG_GLIDE_RATE   = 3'd4;

   typedef struct packed {
      logic [15:0] step_min;
      logic [15:0] step_span;
      logic [15:0] max_delta;
      logic [9:0]  max_frame_ms;
      logic [15:0] glide_rate;
   } cfg_type;

   // one enable per datapath phase
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic step;
      logic acc;
      logic clamp;
      logic glide;
      logic fold;
      logic out_load;
   } cmd_type;

endpackage

>>> rtl/esof_csr.sv
module esof_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [esof_pkg::ADDR_W-1:0]  paddr,
   input  logic [esof_pkg::DATA_W-1:0]  pwdata,
   output logic [esof_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output esof_pkg::cfg_type            cfg
);
   import esof_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[4:2])
            REG_STEP_MIN:     cfg_in.step_min     = pwdata[15:0];
            REG_STEP_SPAN:    cfg_in.step_span    = pwdata[15:0];
            REG_MAX_DELTA:    cfg_in.max_delta    = pwdata[15:0];
            REG_MAX_FRAME_MS: cfg_in.max_frame_ms = pwdata[9:0];
            REG_GLIDE_RATE:   cfg_in.glide_rate   = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_min     <= 16'd256;
         cfg_ff.step_span    <= 16'd4096;
         cfg_ff.max_delta    <= 16'd64;
         cfg_ff.max_frame_ms <= 10'd100;
         cfg_ff.glide_rate   <= 16'd25600;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (paddr[4:2])
         REG_STEP_MIN:     prdata = {16'd0, cfg_ff.step_min};
         REG_STEP_SPAN:    prdata = {16'd0, cfg_ff.step_span};
         REG_MAX_DELTA:    prdata = {16'd0, cfg_ff.max_delta};
         REG_MAX_FRAME_MS: prdata = {22'd0, cfg_ff.max_frame_ms};
         REG_GLIDE_RATE:   prdata = {16'd0, cfg_ff.glide_rate};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/esof_ctrl.sv
module esof_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output esof_pkg::cmd_type  cmd
);
   import esof_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL1  = 9'b000000010,
      ST_MUL2  = 9'b000000100,
      ST_STEP  = 9'b000001000,
      ST_ACC   = 9'b000010000,
      ST_CLAMP = 9'b000100000,
      ST_GLIDE = 9'b001000000,
      ST_FOLD  = 9'b010000000,
      ST_MOD   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // phase sequencing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_STEP;
         ST_STEP:  state_in = ST_ACC;
         ST_ACC:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_GLIDE;
         ST_GLIDE: state_in = ST_FOLD;
         ST_FOLD:  state_in = ST_MOD;
         ST_MOD:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.load     = accept;
      cmd.mul1     = (state_ff == ST_MUL1);
      cmd.mul2     = (state_ff == ST_MUL2);
      cmd.step     = (state_ff == ST_STEP);
      cmd.acc      = (state_ff == ST_ACC);
      cmd.clamp    = (state_ff == ST_CLAMP);
      cmd.glide    = (state_ff == ST_GLIDE);
      cmd.fold     = (state_ff == ST_FOLD);
      cmd.out_load = (state_ff == ST_MOD) && out_free;
   end

   // result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted beat always starts the sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL1))
      else $error("accepted beat did not start the sequence");

   // a new result only comes from the last phase
   a_rsp_from_mod: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MOD))
      else $error("result raised outside the final phase");

   // never overwrite a stalled result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");

endmodule

>>> rtl/esof_dp.sv
module esof_dp (
   input  logic               clock,
   input  logic               reset,
   input  esof_pkg::cfg_type  cfg,
   input  esof_pkg::cmd_type  cmd,
   input  logic signed [31:0] req_encoder_count,
   input  logic [9:0]         req_pot_value,
   input  logic [31:0]        req_time_ms,
   output logic [15:0]        rsp_wrap_offset
);
   import esof_pkg::*;

   // captured beat
   logic [31:0] enc_ff;
   logic [9:0]  pot_ff;
   logic [31:0] now_ff;

   // persistent state
   logic [31:0]               last_enc_ff;
   logic [31:0]               last_time_ff;
   logic signed [31:0]        target_ff;
   logic signed [31:0]        target_in;
   logic signed [SHOWN_W-1:0] shown_ff;
   logic signed [SHOWN_W-1:0] shown_in;

   // intermediates
   logic [PROD_W-1:0]         prod_ff;
   logic signed [17:0]        delta_ff;
   logic                      delta_ok_ff;
   logic [9:0]                elapsed_ff;
   logic [STEP_W-1:0]         q0_ff;
   logic [LIMIT_W-1:0]        limit_ff;
   logic [STEP_W-1:0]         step_ff;
   logic signed [39:0]        tacc_ff;
   logic [31:0]               mag_ff;
   logic                      neg_ff;
   logic [15:0]               out_ff;

   // phase one signals
   logic [31:0]               delta_raw;
   logic signed [32:0]        delta_ext;
   logic [32:0]               delta_mag;
   logic                      delta_ok;
   logic [31:0]               el_raw;
   logic [9:0]                elapsed;

   // divide by POT_MAX
   logic [QPROD_W-1:0]        qprod;
   logic [PROD_W:0]           rem;
   logic                      corr;

   // accumulate
   logic signed [17:0]        step_s;
   logic signed [35:0]        mprod;

   // clamp
   logic signed [WIDE_W-1:0]  tacc_w;
   logic signed [WIDE_W-1:0]  shown_w;
   logic signed [WIDE_W-1:0]  lead;
   logic signed [WIDE_W-1:0]  step_fx;
   logic signed [WIDE_W-1:0]  pick;
   logic signed [WIDE_W-1:0]  pick_t;
   logic signed [WIDE_W-1:0]  tsel;
   logic                      over_hi;
   logic                      over_lo;

   // glide
   logic signed [WIDE_W-1:0]  tgt_fx;
   logic signed [WIDE_W-1:0]  diff;
   logic signed [WIDE_W-1:0]  lim_w;
   logic                      snap;

   // fold and modulo
   logic [SHOWN_W-1:0]        abs_shown;
   logic [16:0]               fold_s;
   logic [16:0]               fold_t;
   logic [15:0]               mod_r;
   logic [15:0]               mod_res;

   // encoder delta and elapsed time
   assign delta_raw = enc_ff - last_enc_ff;
   assign delta_ext = $signed({delta_raw[31], delta_raw});
   assign delta_mag = delta_ext[32] ? 33'(-delta_ext) : 33'(delta_ext);
   assign delta_ok  = (delta_mag <= {17'd0, cfg.max_delta});
   assign el_raw    = now_ff - last_time_ff;
   assign elapsed   = (el_raw > {22'd0, cfg.max_frame_ms}) ? cfg.max_frame_ms : el_raw[9:0];

   // reciprocal estimate, at most one low, then one correction
   assign qprod = QPROD_W'(prod_ff) * QPROD_W'(RECIP);
   assign rem   = (PROD_W+1)'(prod_ff) - (PROD_W+1)'(q0_ff) * (PROD_W+1)'(POT_MAX);
   assign corr  = (rem >= (PROD_W+1)'(POT_MAX));

   // detent motion
   assign step_s = $signed({1'b0, step_ff});
   assign mprod  = delta_ff * step_s;

   // lead clamp around the displayed offset
   assign tacc_w  = $signed({{(WIDE_W-40){tacc_ff[39]}}, tacc_ff});
   assign shown_w = $signed({{(WIDE_W-SHOWN_W){shown_ff[SHOWN_W-1]}}, shown_ff});
   assign step_fx = $signed({{(WIDE_W-STEP_W){1'b0}}, step_ff} << FRAC_BITS);
   assign lead    = (tacc_w <<< FRAC_BITS) - shown_w;
   assign pick    = (lead > step_fx) ? (shown_w + step_fx) : (shown_w - step_fx);
   assign pick_t  = (pick + $signed(pick[WIDE_W-1] ? FRAC_MASK : WIDE_W'(0))) >>> FRAC_BITS;
   assign tsel    = ((lead > step_fx) || (lead < -step_fx)) ? pick_t : tacc_w;
   assign over_hi = (tsel > 48'sh0000_7FFF_FFFF);
   assign over_lo = (tsel < 48'shFFFF_8000_0000);

   always_comb begin
      if (over_hi) begin
         target_in = 32'sh7FFF_FFFF;
      end else if (over_lo) begin
         target_in = 32'sh8000_0000;
      end else begin
         target_in = tsel[31:0];
      end
   end

   // glide toward the target
   assign tgt_fx = $signed({{(WIDE_W-32){target_ff[31]}}, target_ff}) <<< FRAC_BITS;
   assign diff   = tgt_fx - shown_w;
   assign lim_w  = $signed({{(WIDE_W-LIMIT_W){1'b0}}, limit_ff});
   assign snap   = (diff <= lim_w) && (diff >= -lim_w);

   always_comb begin
      if (snap) begin
         shown_in = tgt_fx[SHOWN_W-1:0];
      end else if (diff > 0) begin
         shown_in = shown_ff + SHOWN_W'(limit_ff);
      end else begin
         shown_in = shown_ff - SHOWN_W'(limit_ff);
      end
   end

   // magnitude of the integer part, then fold modulo 65535
   assign abs_shown = shown_ff[SHOWN_W-1] ? SHOWN_W'(-shown_ff) : SHOWN_W'(shown_ff);
   assign fold_s    = {1'b0, mag_ff[31:16]} + {1'b0, mag_ff[15:0]};
   assign fold_t    = {16'd0, fold_s[16]} + {1'b0, fold_s[15:0]};
   assign mod_r     = (fold_t == 17'(WRAP_MOD)) ? 16'd0 : fold_t[15:0];
   assign mod_res   = (neg_ff && (mod_r != 16'd0)) ? (16'(WRAP_MOD) - mod_r) : mod_r;

   // beat capture and intermediates
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         enc_ff <= req_encoder_count;
         pot_ff <= req_pot_value;
         now_ff <= req_time_ms;
      end
      if (cmd.mul1) begin
         prod_ff     <= PROD_W'(cfg.step_span) * PROD_W'(pot_ff);
         delta_ff    <= $signed(delta_raw[17:0]);
         delta_ok_ff <= delta_ok;
         elapsed_ff  <= elapsed;
      end
      if (cmd.mul2) begin
         q0_ff    <= qprod[RECIP_SH +: STEP_W];
         limit_ff <= LIMIT_W'(cfg.glide_rate) * LIMIT_W'(elapsed_ff);
      end
      if (cmd.step) begin
         step_ff <= STEP_W'(cfg.step_min) + q0_ff + STEP_W'(corr);
      end
      if (cmd.acc) begin
         tacc_ff <= {{8{target_ff[31]}}, target_ff}
                  + (delta_ok_ff ? {{4{mprod[35]}}, mprod} : 40'd0);
      end
      if (cmd.fold) begin
         mag_ff <= abs_shown[FRAC_BITS +: 32];
         neg_ff <= shown_ff[SHOWN_W-1];
      end
      if (cmd.out_load) begin
         out_ff <= mod_res;
      end
   end

   // state carried between frames
   always_ff @(posedge clock) begin
      if (reset) begin
         last_enc_ff  <= '0;
         last_time_ff <= '0;
         target_ff    <= '0;
         shown_ff     <= '0;
      end else begin
         if (cmd.mul1) begin
            last_enc_ff  <= enc_ff;
            last_time_ff <= now_ff;
         end
         if (cmd.clamp) begin
            target_ff <= target_in;
         end
         if (cmd.glide) begin
            shown_ff <= shown_in;
         end
      end
   end

   assign rsp_wrap_offset = out_ff;

   // reciprocal estimate is never more than one short
   a_recip_close: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (rem < (PROD_W+1)'(2 * POT_MAX)))
      else $error("reciprocal quotient off by more than one");

   // a snap lands exactly on the target
   a_snap_exact: assert property (@(posedge clock) disable iff (reset)
      (cmd.glide && snap) |=> (shown_ff == $past(tgt_fx[SHOWN_W-1:0])))
      else $error("displayed offset missed the target on snap");

endmodule

>>> rtl/encoder_slew_offset_follower.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_encoder_count, req_pot_value, req_time_ms
// rsp       out        rsp_valid / rsp_stall  rsp_wrap_offset
// csr       in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one frame beat runs from accept through eight phases of the shared datapath
// (two multiply phases, step correction, accumulate, clamp, glide, fold,
// modulo) before the next beat can be accepted.
// the result sits in an output register; a new beat is accepted while it waits.
// a stalled result holds the last phase until the output register frees up.
// synchronous reset restores register defaults and zeroes all frame state.
module encoder_slew_offset_follower (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [31:0]           req_encoder_count,
   input  logic [9:0]                   req_pot_value,
   input  logic [31:0]                  req_time_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [15:0]                  rsp_wrap_offset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [esof_pkg::ADDR_W-1:0]  paddr,
   input  logic [esof_pkg::DATA_W-1:0]  pwdata,
   output logic [esof_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);
   import esof_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   // register block
   esof_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // phase sequencer
   esof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic
   esof_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .req_encoder_count (req_encoder_count),
      .req_pot_value     (req_pot_value),
      .req_time_ms       (req_time_ms),
      .rsp_wrap_offset   (rsp_wrap_offset)
   );

endmodule

>>> sim/tb_encoder_slew_offset_follower.sv
`timescale 1ns / 1ps

module tb_encoder_slew_offset_follower;
   import esof_pkg::*;

   localparam longint ONE       = longint'(1) << FRAC_BITS;
   localparam int     HOLD_LEN  = 400;
   localparam int     SETTLE    = 24;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [31:0] enc;
      logic [9:0]  pot;
      logic [31:0] t;
   } frame_type;

   logic clock = 1'b0;
   logic reset;

   logic                req_valid;
   logic                req_stall;
   logic signed [31:0]  req_encoder_count;
   logic [9:0]          req_pot_value;
   logic [31:0]         req_time_ms;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [15:0]         rsp_wrap_offset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   encoder_slew_offset_follower dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_encoder_count (req_encoder_count),
      .req_pot_value     (req_pot_value),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_wrap_offset   (rsp_wrap_offset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   // predictor copy of the configuration and frame state
   cfg_type     cfg = '{step_min: 16'd256, step_span: 16'd4096, max_delta: 16'd64,
                        max_frame_ms: 10'd100, glide_rate: 16'd25600};
   logic [31:0] last_enc  = '0;
   longint      target    = 0;
   longint      shown     = 0;
   logic [31:0] last_t    = '0;

   frame_type   frame_q[$];
   logic [15:0] offset_q[$];
   frame_type   offered;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          hold_left     = 0;
   int          mismatches    = 0;
   logic [31:0] enc_sent  = '0;
   logic [31:0] time_sent = '0;

   // one display frame through the follower, returns the wrapped offset
   function automatic logic [15:0] follow_frame(frame_type f);
      longint             step, step_fx, delta, md, lead, diff, limit, whole, m;
      logic signed [31:0] d32;
      logic [31:0]        elapsed;
      step = longint'(cfg.step_min)
           + (longint'(cfg.step_span) * longint'(f.pot)) / POT_MAX;

      // encoder motion, large jumps are dropped
      d32 = f.enc - last_enc;
      delta = longint'(d32);
      last_enc = f.enc;
      md = longint'(cfg.max_delta);
      if (delta <= md && delta >= -md) target += delta * step;

      // keep the target within one step of the displayed offset
      lead = target * ONE - shown;
      step_fx = step * ONE;
      if (lead > step_fx) target = (shown + step_fx) / ONE;
      else if (lead < -step_fx) target = (shown - step_fx) / ONE;
      if (target > 64'sd2147483647) target = 64'sd2147483647;
      if (target < -64'sd2147483648) target = -64'sd2147483648;

      // glide toward the target, bounded by rate times capped elapsed time
      elapsed = f.t - last_t;
      last_t = f.t;
      if (elapsed > 32'(cfg.max_frame_ms)) elapsed = 32'(cfg.max_frame_ms);
      limit = longint'(cfg.glide_rate) * longint'(elapsed);
      diff = target * ONE - shown;
      if (diff <= limit && diff >= -limit) shown = target * ONE;
      else shown += (diff > 0) ? limit : -limit;

      whole = shown / ONE;
      m = whole % WRAP_MOD;
      if (m < 0) m += WRAP_MOD;
      return m[15:0];
   endfunction

   // input driver: offers queued frames, predicts on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) offset_q.push_back(follow_frame(offered));
         if (req_valid && req_stall) begin
            // hold the stalled beat
         end else if (frame_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            offered = frame_q.pop_front();
            req_valid         <= 1'b1;
            req_encoder_count <= offered.enc;
            req_pot_value     <= offered.pot;
            req_time_ms       <= offered.t;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (offset_q.size() == 0) begin
               $display("%0t: offset %0d with no frame outstanding",
                        $time, rsp_wrap_offset);
               mismatches++;
            end else if (rsp_wrap_offset !== offset_q[0]) begin
               $display("%0t: offset expected %0d, got %0d",
                        $time, offset_q[0], rsp_wrap_offset);
               mismatches++;
               void'(offset_q.pop_front());
            end else begin
               void'(offset_q.pop_front());
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
      end
   end

   // long receiver hold-off, counted down here
   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_STEP_MIN:     cfg.step_min     = val[15:0];
         REG_STEP_SPAN:    cfg.step_span    = val[15:0];
         REG_MAX_DELTA:    cfg.max_delta    = val[15:0];
         REG_MAX_FRAME_MS: cfg.max_frame_ms = val[9:0];
         REG_GLIDE_RATE:   cfg.glide_rate   = val[15:0];
         default: ;
      endcase
   endtask

   // wait until every frame is accepted and every offset returned
   task automatic drain();
      while (frame_q.size() != 0 || req_valid || offset_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic push_frame(input logic [31:0] enc, input logic [9:0] pot,
                             input logic [31:0] t);
      frame_type f;
      f.enc = enc;
      f.pot = pot;
      f.t   = t;
      enc_sent  = enc;
      time_sent = t;
      frame_q.push_back(f);
   endtask

   // mostly smooth knob motion, some wild jumps of count and clock
   task automatic queue_frames(input int n);
      int          d;
      int          md;
      int          span;
      logic [31:0] enc;
      logic [31:0] t;
      logic [9:0]  pot;
      for (int i = 0; i < n; i++) begin
         md = int'(cfg.max_delta);
         span = int'(cfg.max_frame_ms) + int'(cfg.max_frame_ms) / 2 + 2;
         if ($urandom_range(0, 99) < 12) begin
            enc = $urandom;
            t   = $urandom;
         end else begin
            d   = int'($urandom_range(0, 2 * md + 4)) - md - 2;
            enc = enc_sent + d;
            t   = ($urandom_range(0, 9) == 0) ? time_sent
                                              : time_sent + $urandom_range(0, span);
         end
         case ($urandom_range(0, 7))
            0:       pot = 10'd0;
            1:       pot = 10'd1023;
            default: pot = 10'($urandom_range(0, 1023));
         endcase
         push_frame(enc, pot, t);
      end
   endtask

   // steady forward motion at full step
   task automatic queue_climb(input int n);
      for (int i = 0; i < n; i++)
         push_frame(enc_sent + $urandom_range(1, 65535), 10'd1023,
                    time_sent + $urandom_range(1000, 5000));
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 300));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(input cfg_type c, input idle_mode_type mode, input int n,
                            input bit climb);
      drain();
      csr_write(REG_STEP_MIN,     32'(c.step_min));
      csr_write(REG_STEP_SPAN,    32'(c.step_span));
      csr_write(REG_MAX_DELTA,    32'(c.max_delta));
      csr_write(REG_MAX_FRAME_MS, 32'(c.max_frame_ms));
      csr_write(REG_GLIDE_RATE,   32'(c.glide_rate));
      @(negedge clock);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 51; stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 51; end
         default:   begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      if (climb) queue_climb(n);
      else queue_frames(n);
   endtask

   // run ceiling
   initial begin
      #30_000_000;
      $display("encoder_slew_offset_follower: mismatch");
      $finish;
   end

   // stimulus sequence
   initial begin
      cfg_type c;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_encoder_count = '0;
      req_pot_value     = '0;
      req_time_ms       = '0;
      rsp_stall         = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames on the reset configuration
      push_frame(32'd0,          10'd0,    32'd0);           // nothing moves, no time
      push_frame(32'd64,         10'd1023, 32'd5);           // exactly +max_delta, full pot
      push_frame(32'd0,          10'd512,  32'd10);          // exactly -max_delta
      push_frame(32'hFFFF_FFBF,  10'd0,    32'd200);         // -65 rejected, elapsed capped
      push_frame(32'h7FFF_FFFF,  10'd1023, 32'd200);         // huge jump, zero elapsed
      push_frame(32'h8000_0000,  10'd0,    32'hFFFF_FFF0);   // count wraps to a +1 step
      push_frame(32'h7FFF_FFD8,  10'd700,  32'h0000_0010);   // clock wraps
      push_frame(32'h7FFF_FFB0,  10'd1023, 32'h0000_0020);   // drive the offset negative
      push_frame(32'h7FFF_FF88,  10'd1023, 32'h0000_0040);
      push_frame(32'h7FFF_FF60,  10'd1023, 32'h0000_0060);
      push_frame(32'h7FFF_FF38,  10'd1023, 32'h0000_0080);
      push_frame(32'h7FFF_FF38,  10'd1023, 32'h0000_0080);   // zero limit, gap left open
      push_frame(32'h7FFF_FF79,  10'd1023, 32'h0000_00A0);   // +65 rejected
      push_frame(32'h7FFF_FF79,  10'd1,    32'h0000_0400);
      drain();
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);                  // unmapped write is dropped
      @(negedge clock);
      push_frame(enc_sent + 32'd3, 10'd300, time_sent + 32'd7);
      push_frame(enc_sent - 32'd9, 10'd900, time_sent + 32'd150);

      // reset values again, with a long receiver hold-off
      c = '{step_min: 16'd256, step_span: 16'd4096, max_delta: 16'd64,
            max_frame_ms: 10'd100, glide_rate: 16'd25600};
      run_phase(c, IDLE_NONE, 250, 1'b0);
      hold_left = HOLD_LEN;

      // all registers at the bottom, then all at the top
      c = '{step_min: 16'd0, step_span: 16'd0, max_delta: 16'd0,
            max_frame_ms: 10'd0, glide_rate: 16'd0};
      run_phase(c, IDLE_SEND, 250, 1'b0);
      c = '{step_min: 16'hFFFF, step_span: 16'hFFFF, max_delta: 16'hFFFF,
            max_frame_ms: 10'd1000, glide_rate: 16'hFFFF};
      run_phase(c, IDLE_RECV, 250, 1'b0);

      // random settings across the idling patterns
      for (int p = 3; p < 8; p++) begin
         c.step_min   = pick16();
         c.step_span  = pick16();
         c.max_delta  = pick16();
         case ($urandom_range(0, 3))
            0:       c.max_frame_ms = 10'd0;
            1:       c.max_frame_ms = 10'd1000;
            default: c.max_frame_ms = 10'($urandom_range(0, 1000));
         endcase
         c.glide_rate = pick16();
         run_phase(c, idle_mode_type'(p % 4), 200, 1'b0);
      end

      // long climb at full step, then wander with a tighter jump limit
      c = '{step_min: 16'hFFFF, step_span: 16'hFFFF, max_delta: 16'hFFFF,
            max_frame_ms: 10'd1000, glide_rate: 16'hFFFF};
      run_phase(c, IDLE_NONE, 150, 1'b1);
      c.max_delta = 16'd200;
      run_phase(c, IDLE_BOTH, 100, 1'b0);

      drain();
      if (mismatches == 0)
         $display("encoder_slew_offset_follower: match");
      else
         $display("encoder_slew_offset_follower: mismatch");
      $finish;
   end

endmodule
